// ===== rtl/grid_flood_fill_relabel_macros.svh =====
// Assertion macros shared by the grid fill block.
`ifndef GRID_FLOOD_FILL_RELABEL_MACROS_SVH
`define GRID_FLOOD_FILL_RELABEL_MACROS_SVH
// Implication checked every clock outside reset.
`define GFF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define GFF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/gff_pkg.sv =====
// Package: types, constants and states for the grid fill block.
`timescale 1ns / 1ps
package gff_pkg;
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int DEF_ZONE_BITS  = 8;
  localparam int TERRAIN_BITS   = 4;
  localparam int COORD_BITS     = 6;
  localparam int CFG_BITS       = 7;
  localparam int ZONE_IN_BITS   = 8;
  localparam int COUNT_BITS     = 13;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_FILL  = 2'd2;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_SEED, ST_SEED, ST_POP, ST_POP_WAIT, ST_NB, ST_NB_WAIT,
    ST_NB_CHK, ST_FIN_RD, ST_FIN, ST_OUT
  } state_t;
endpackage

// ===== rtl/gff_queue.sv =====
// Pending tile queue for the breadth-first walk.
`timescale 1ns / 1ps
module gff_queue import gff_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          clear,
  input  logic          push,
  input  logic [AW-1:0] push_data,
  input  logic          pop,
  output logic [AW-1:0] pop_data,
  output logic          empty
);
  logic [AW-1:0] mem [DEPTH];
  logic [AW:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [AW:0] tail_base;
  logic        push_ok;

  // a push in the clear cycle lands in entry 0
  always_comb begin
    tail_base = clear ? '0 : tail_r;
    push_ok   = push && (tail_base < (AW+1)'(DEPTH));
    head_nxt  = clear ? '0 : head_r + (AW+1)'(pop);
    tail_nxt  = tail_base + (AW+1)'(push_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) mem[tail_base[AW-1:0]] <= push_data;
    if (pop) pop_data <= mem[head_r[AW-1:0]];
  end

  assign empty = (head_r >= tail_r) || (head_r >= (AW+1)'(DEPTH));
endmodule

// ===== rtl/grid_flood_fill_relabel.sv =====
// Top level: tile grid with read, write and 4-connected flood fill.
// Channel | direction | tdata bits (low first)
// in_     | slave     | action[1:0] tile_x[7:2] tile_y[13:8] terrain[17:14] zone[25:18]
// out_    | master    | status[0] terrain[4:1] zone[12:5] count[25:13]
// cfg_    | slave     | cfg_index 0 width, 1 height; cfg_data 7 bits
// An out-of-grid item skips the tile memory and goes straight to the result.
// A fill pops each relabelled tile and reads each in-grid neighbour, skipping
// neighbours off the grid; a fill whose zone is unchanged relabels only the seed.
// The tile memory has a single port, which the sequencer shares among these steps.
// Reset clears the sequencer and queue pointers; the tile memory is not cleared.
// in_tready is low from acceptance until the result transfer on out_.
`timescale 1ns / 1ps
module grid_flood_fill_relabel import gff_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int ZONE_BITS  = DEF_ZONE_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // action, tile_x, tile_y, terrain_in, zone_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // status, terrain_out, zone_out, relabelled_count
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);
  `include "grid_flood_fill_relabel_macros.svh"
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = XW + YW;
  localparam int TW = TERRAIN_BITS + ZONE_BITS;

  state_t state_r, state_nxt;
  logic [CFG_BITS-1:0] gw_r, gh_r;
  logic [1:0] act_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic [TERRAIN_BITS-1:0] ter_r;
  logic [ZONE_BITS-1:0] zone_r, old_r;
  logic [XW-1:0] cx_r;
  logic [YW-1:0] cy_r;
  logic [1:0] dir_r;
  logic [AW-1:0] nb_r;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [25:0] res_r;

  // tile memory, one port, addressed {y, x}
  logic [TW-1:0] tiles [2**AW];
  logic [TW-1:0] rd_q;
  logic mem_we, mem_re;
  logic [AW-1:0] mem_a;
  logic [TW-1:0] mem_d;
  always_ff @(posedge clk) begin
    if (mem_we) tiles[mem_a] <= mem_d;
    if (mem_re) rd_q <= tiles[mem_a];
  end

  logic q_clear, q_push, q_pop, q_empty;
  logic [AW-1:0] q_data;
  logic [AW-1:0] q_wdata;
  gff_queue #(.DEPTH(2**AW)) u_queue (
    .clk, .rst_n, .clear(q_clear), .push(q_push), .push_data(q_wdata),
    .pop(q_pop), .pop_data(q_data), .empty(q_empty));

  // clamped grid size
  logic [10:0] uw, uh;
  assign uw = (32'(gw_r) > MAX_WIDTH) ? 11'(MAX_WIDTH) : 11'(gw_r);
  assign uh = (32'(gh_r) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : 11'(gh_r);
  logic oor;
  assign oor = (11'(in_tdata[7:2]) >= uw) || (11'(in_tdata[13:8]) >= uh);

  logic [AW-1:0] seed_a;
  assign seed_a = {YW'(y_r), XW'(x_r)};

  // seed goes in first, in the clear cycle; neighbours follow from nb_r
  assign q_wdata = (state_r == ST_SEED) ? seed_a : nb_r;

  // neighbour candidate for current direction
  logic signed [11:0] nx, ny;
  logic nb_ok;
  always_comb begin
    nx = 12'($signed({1'b0, cx_r}));
    ny = 12'($signed({1'b0, cy_r}));
    case (dir_r)
      2'd0: ny = ny + 12'sd1;
      2'd1: nx = nx + 12'sd1;
      2'd2: ny = ny - 12'sd1;
      default: nx = nx - 12'sd1;
    endcase
    nb_ok = !nx[11] && !ny[11] && (nx[10:0] < uw) && (ny[10:0] < uh);
  end

  logic match;
  assign match = rd_q[TW-1:ZONE_BITS] == ter_r && rd_q[ZONE_BITS-1:0] == old_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = oor ? ST_OUT : ST_RD_SEED;
      ST_RD_SEED: state_nxt = (act_r == ACT_FILL) ? ST_SEED : ST_FIN_RD;
      ST_SEED: state_nxt = (rd_q[ZONE_BITS-1:0] == zone_r) ? ST_FIN_RD : ST_POP;
      ST_POP: state_nxt = q_empty ? ST_FIN_RD : ST_POP_WAIT;
      ST_POP_WAIT: state_nxt = ST_NB;
      ST_NB: state_nxt = nb_ok ? ST_NB_WAIT : ((dir_r == 2'd3) ? ST_POP : ST_NB);
      ST_NB_WAIT: state_nxt = ST_NB_CHK;
      ST_NB_CHK: state_nxt = (dir_r == 2'd3) ? ST_POP : ST_NB;
      ST_FIN_RD: state_nxt = ST_FIN;
      ST_FIN: state_nxt = ST_OUT;
      ST_OUT: if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0; mem_re = 1'b0; mem_a = seed_a; mem_d = {ter_r, zone_r};
    q_clear = 1'b0; q_push = 1'b0; q_pop = 1'b0;
    case (state_r)
      ST_RD_SEED: begin
        mem_we = (act_r == ACT_WRITE); mem_re = (act_r == ACT_FILL);
      end
      ST_SEED: begin
        mem_we = 1'b1; q_clear = 1'b1;
        q_push = (rd_q[ZONE_BITS-1:0] != zone_r);
      end
      ST_POP: q_pop = !q_empty;
      ST_NB: begin mem_re = nb_ok; mem_a = {ny[YW-1:0], nx[XW-1:0]}; end
      ST_NB_CHK: begin
        mem_a = nb_r; mem_d = {ter_r, zone_r};
        mem_we = match; q_push = match;
      end
      ST_FIN_RD: mem_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; gw_r <= 7'd64; gh_r <= 7'd64;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) gw_r <= cfg_data;
        else gh_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (in_tvalid) begin
        act_r <= in_tdata[1:0]; x_r <= in_tdata[7:2]; y_r <= in_tdata[13:8];
        ter_r <= in_tdata[17:14]; zone_r <= ZONE_BITS'(in_tdata[25:18]);
        cnt_r <= '0; res_r <= 26'd1;
      end
      ST_RD_SEED: cnt_r <= (act_r == ACT_FILL) ? 13'd1 : '0;
      ST_SEED: begin old_r <= rd_q[ZONE_BITS-1:0]; end
      ST_POP_WAIT: begin cx_r <= q_data[XW-1:0]; cy_r <= q_data[AW-1:XW]; dir_r <= 2'd0; end
      ST_NB: begin
        nb_r <= {ny[YW-1:0], nx[XW-1:0]};
        if (!nb_ok) dir_r <= dir_r + 2'd1;
      end
      ST_NB_CHK: begin
        if (match) cnt_r <= cnt_r + 13'd1;
        dir_r <= dir_r + 2'd1;
      end
      ST_FIN: res_r <= {cnt_r, 8'(rd_q[ZONE_BITS-1:0]), rd_q[TW-1:ZONE_BITS], 1'b0};
      default: ;
    endcase
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {6'd0, res_r};

  `GFF_ASSERT_IMP(a_out_only_done, out_tvalid, !in_tready)
  `GFF_ASSERT_NEXT(a_ret_idle, out_tvalid && out_tready, in_tready)
  `GFF_ASSERT_IMP(a_no_we_idle, state_r == ST_IDLE, !mem_we)
endmodule

// ===== sim/tb_grid_flood_fill_relabel.sv =====
// Testbench for the tile grid block: a scoreboard class predicts reads, writes and fills.
`timescale 1ns / 1ps

// Holds the predicted grid and the queue of predicted results for each transfer on in_.
class tile_scoreboard;
  logic [3:0]  terr [4096];
  logic [7:0]  zn   [4096];
  bit          known[4096];
  int unsigned width_cfg, height_cfg;
  logic [25:0] pending_results[$];
  int          mismatches;
  logic [11:0] bfs_q[4096];

  function new();
    width_cfg  = 64;
    height_cfg = 64;
    mismatches = 0;
    foreach (known[i]) known[i] = 0;
  endfunction

  function int unsigned used_w();
    return (width_cfg > 64) ? 64 : width_cfg;
  endfunction

  function int unsigned used_h();
    return (height_cfg > 64) ? 64 : height_cfg;
  endfunction

  // Walks breadth first from the seed and returns the relabelled count.
  function int unsigned fill(int unsigned seed, logic [3:0] t, logic [7:0] z);
    int unsigned head, tail, cnt, cx, cy, n, d;
    int nx, ny;
    logic [7:0] old;
    int dx[4];
    int dy[4];
    dx = '{0, 1, 0, -1};
    dy = '{1, 0, -1, 0};
    old = zn[seed];
    cnt = 1;
    terr[seed] = t;
    zn[seed] = z;
    known[seed] = 1;
    if (z == old) return cnt;
    head = 0;
    tail = 0;
    bfs_q[tail++] = 12'(seed);
    while (head < tail) begin
      cx = 32'(bfs_q[head]) % 64;
      cy = 32'(bfs_q[head]) / 64;
      head++;
      for (d = 0; d < 4; d++) begin
        nx = int'(cx) + dx[d];
        ny = int'(cy) + dy[d];
        if (nx < 0 || ny < 0 || nx >= int'(used_w()) || ny >= int'(used_h())) continue;
        n = ny * 64 + nx;
        if (terr[n] == t && zn[n] == old) begin
          zn[n] = z;
          cnt++;
          bfs_q[tail++] = 12'(n);
        end
      end
    end
    return cnt;
  endfunction

  // Notes an accepted input transfer and queues its predicted result.
  function void note_input(logic [25:0] d);
    logic [1:0] act;
    int unsigned x, y, idx, cnt;
    logic [25:0] res;
    act = d[1:0];
    x = 32'(d[7:2]);
    y = 32'(d[13:8]);
    cnt = 0;
    if (x >= used_w() || y >= used_h()) begin
      res = 26'd1;
      pending_results = {pending_results, res};
      return;
    end
    idx = y * 64 + x;
    if (act == gff_pkg::ACT_WRITE) begin
      terr[idx] = d[17:14];
      zn[idx] = d[25:18];
      known[idx] = 1;
    end else if (act == gff_pkg::ACT_FILL) begin
      cnt = fill(idx, d[17:14], d[25:18]);
    end
    res = {cnt[12:0], zn[idx], terr[idx], 1'b0};
    pending_results = {pending_results, res};
  endfunction

  // Compares a result transfer with the oldest prediction.
  function void check_result(logic [25:0] got);
    logic [25:0] exp_r;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = pending_results.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: status %0d/%0d terrain %0d/%0d zone %0d/%0d count %0d/%0d",
                 exp_r[0], got[0], exp_r[4:1], got[4:1], exp_r[12:5], got[12:5],
                 exp_r[25:13], got[25:13]);
    end
  endfunction
endclass

module tb_grid_flood_fill_relabel;
  import gff_pkg::*;

  localparam longint CYCLE_LIMIT = 3_000_000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  tile_scoreboard sb;
  longint cycle_count = 0;
  bit     hold_sink = 0;   // long receiver stall requested by the stimulus
  bit     stall_free = 0;  // no random stalls while set

  grid_flood_fill_relabel dut (.*);

  always #5 clk = ~clk;

  // Timeout guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("grid_flood_fill_relabel verification failed");
      $finish;
    end
  end

  // Receiver: random ready, checks each result transfer.
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[25:0]);
    if (hold_sink) begin
      out_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 0;
    end else if (!stall_free && $urandom_range(0, 3) == 0) begin
      hold_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  // Sends one item; waits for its transfer, then maybe a random gap.
  task automatic send_item(logic [1:0] act, logic [5:0] x, logic [5:0] y,
                           logic [3:0] t, logic [7:0] z);
    int gap;
    in_tdata  <= {6'd0, z, t, y, x, act};
    in_tvalid <= 1;
    do @(posedge clk); while (!in_tready);
    sb.note_input({z, t, y, x, act});
    gap = stall_free ? 0 : (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2));
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_BITS-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == CFG_WIDTH) sb.width_cfg = 32'(val); else sb.height_cfg = 32'(val);
    @(posedge clk);
  endtask

  // Writes every tile of the used area, few terrains and zones so fills spread.
  task automatic load_grid(int unsigned w, int unsigned h);
    for (int yy = 0; yy < h; yy++)
      for (int xx = 0; xx < w; xx++)
        send_item(ACT_WRITE, 6'(xx), 6'(yy), 4'($urandom_range(0, 1)),
                  8'($urandom_range(0, 1)));
  endtask

  // Picks a random item; only known tiles are ever read or filled.
  task automatic random_item(int unsigned w, int unsigned h);
    logic [1:0] act;
    logic [5:0] x, y;
    int unsigned r;
    r = $urandom_range(0, 9);
    act = (r < 4) ? ACT_WRITE : (r < 6) ? ACT_READ : (r < 9) ? ACT_FILL : ACT_UNUSED;
    if ($urandom_range(0, 7) == 0) begin
      x = 6'($urandom);
      y = 6'($urandom);
    end else begin
      x = 6'($urandom_range(0, w - 1));
      y = 6'($urandom_range(0, h - 1));
    end
    // Keep reads and fills on written tiles when inside the grid.
    if (x < sb.used_w() && y < sb.used_h() && act != ACT_WRITE && !sb.known[y * 64 + x])
      act = ACT_WRITE;
    send_item(act, x, y,
              4'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1)),
              8'(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2)));
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Small grid, directed part.
    write_cfg(CFG_WIDTH, 7'd4);
    write_cfg(CFG_HEIGHT, 7'd3);
    for (int yy = 0; yy < 3; yy++)
      for (int xx = 0; xx < 4; xx++) send_item(ACT_WRITE, 6'(xx), 6'(yy), 4'd5, 8'd9);
    send_item(ACT_READ, 6'd3, 6'd2, 4'd0, 8'd0);
    send_item(ACT_UNUSED, 6'd0, 6'd0, 4'hf, 8'hff); // unused action reads
    send_item(ACT_FILL, 6'd1, 6'd1, 4'd5, 8'd9);    // unchanged zone
    send_item(ACT_FILL, 6'd0, 6'd0, 4'd5, 8'hff);   // spreads over whole grid
    send_item(ACT_FILL, 6'd2, 6'd1, 4'hf, 8'd0);    // terrain mismatch stops it
    send_item(ACT_WRITE, 6'd4, 6'd0, 4'd1, 8'd1);   // outside width
    send_item(ACT_READ, 6'd0, 6'd3, 4'd0, 8'd0);    // outside height
    send_item(ACT_FILL, 6'd63, 6'd63, 4'hf, 8'hff); // outside
    wait_drained();

    // Zero-size grid: everything outside.
    write_cfg(CFG_WIDTH, 7'd0);
    write_cfg(CFG_HEIGHT, 7'd0);
    send_item(ACT_READ, 6'd0, 6'd0, 4'd0, 8'd0);
    wait_drained();

    // Oversized registers clamp to 64; work in the far corner, walled off by terrain.
    write_cfg(CFG_WIDTH, 7'd127);
    write_cfg(CFG_HEIGHT, 7'd100);
    send_item(ACT_WRITE, 6'd63, 6'd63, 4'd2, 8'd7);
    send_item(ACT_WRITE, 6'd62, 6'd63, 4'd3, 8'd7);
    send_item(ACT_WRITE, 6'd63, 6'd62, 4'd3, 8'd7);
    send_item(ACT_WRITE, 6'd63, 6'd0, 4'hf, 8'hff);
    send_item(ACT_FILL, 6'd63, 6'd63, 4'd2, 8'd8);
    send_item(ACT_READ, 6'd63, 6'd0, 4'd0, 8'd0);
    send_item(ACT_READ, 6'd62, 6'd63, 4'd0, 8'd0);
    wait_drained();

    // Random phases on small grids.
    for (int ph = 0; ph < 3; ph++) begin
      int unsigned w, h;
      w = $urandom_range(1, 4);
      h = $urandom_range(1, 4);
      write_cfg(CFG_WIDTH, 7'(w));
      write_cfg(CFG_HEIGHT, 7'(h));
      load_grid(w, h);
      for (int i = 0; i < 10; i++) random_item(w, h);
      wait_drained();
    end

    // Receiver holds off for a long stretch while the sender keeps offering.
    stall_free = 1;
    hold_sink = 1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_sink = 0;
      end
      for (int i = 0; i < 10; i++) random_item(sb.used_w(), sb.used_h());
    join
    stall_free = 0;
    wait_drained();

    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("grid_flood_fill_relabel verification clean");
    end else begin
      $display("grid_flood_fill_relabel verification failed");
    end
    $finish;
  end
endmodule
